/* rtl/core/plm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package plm_pkg;

    // timestamp table
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int TIME_W      = 48;
    localparam int ENTRY_W     = TIME_W + 1;

    // field widths
    localparam int MODE_W    = 3;
    localparam int TAG_W     = 10;
    localparam int NOW_W     = 48;
    localparam int DELAY_W   = 32;
    localparam int REMOVED_W = 11;
    localparam int COUNT_W   = 32;
    localparam int SUM_W     = 64;

    localparam logic [REMOVED_W-1:0] REMOVED_MAX = '1;
    localparam logic [NOW_W-1:0]     AGING_RESET = NOW_W'(1000000);

    // stream packing
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 272;

    localparam int OFS_DELAY   = 0;
    localparam int OFS_REMOVED = OFS_DELAY + DELAY_W;
    localparam int OFS_COUNT   = OFS_REMOVED + REMOVED_W;
    localparam int OFS_SUM     = OFS_COUNT + COUNT_W;
    localparam int OFS_SQSUM   = OFS_SUM + SUM_W;
    localparam int OFS_MIN     = OFS_SQSUM + SUM_W;
    localparam int OFS_MAX     = OFS_MIN + DELAY_W;
    localparam int OUT_USED_W  = OFS_MAX + DELAY_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_INGRESS   = 3'd0,
        MODE_EGRESS    = 3'd1,
        MODE_SWEEP     = 3'd2,
        MODE_CLR_STATS = 3'd3,
        MODE_CLR_TABLE = 3'd4
    } t_mode;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic sweep_all;
        logic ingress_wr;
        logic evict;
        logic accum;
        logic sqsum;
        logic stats_clr;
        logic scan_clr;
        logic scan_rd;
        logic init_wr;
        logic out_load;
    } t_plm_cmd;

    // datapath to controller
    typedef struct packed {
        logic early;
        logic hit;
        logic scan_last;
        logic out_free;
    } t_plm_sts;

endpackage

`default_nettype wire

/* rtl/core/plm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module plm_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_tvalid,
    input  wire [plm_pkg::MODE_W-1:0] i_mode,
    output logic                   o_s_tready,
    input  plm_pkg::t_plm_sts      i_sts,
    output plm_pkg::t_plm_cmd      o_cmd
);
    import plm_pkg::*;

    typedef enum logic [8:0] {
        S_INIT       = 9'b000000001,
        S_IDLE       = 9'b000000010,
        S_DELAY      = 9'b000000100,
        S_ACCUM      = 9'b000001000,
        S_SQSUM      = 9'b000010000,
        S_SWEEP      = 9'b000100000,
        S_SWEEP_TAIL = 9'b001000000,
        S_RESP       = 9'b010000000,
        S_SPARE      = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                // clearing pass over the valid bits after reset
                o_cmd.init_wr = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture   = 1'b1;
                    o_cmd.sweep_all = (i_mode == MODE_CLR_TABLE);
                    unique case (i_mode)
                        MODE_INGRESS: begin
                            o_cmd.ingress_wr = 1'b1;
                            n_state = S_RESP;
                        end
                        MODE_EGRESS: begin
                            n_state = S_DELAY;
                        end
                        MODE_SWEEP: begin
                            o_cmd.scan_clr = 1'b1;
                            n_state = i_sts.early ? S_RESP : S_SWEEP;
                        end
                        MODE_CLR_STATS: begin
                            o_cmd.stats_clr = 1'b1;
                            n_state = S_RESP;
                        end
                        MODE_CLR_TABLE: begin
                            o_cmd.scan_clr = 1'b1;
                            n_state = S_SWEEP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_DELAY: begin
                o_cmd.evict = 1'b1;
                n_state = i_sts.hit ? S_ACCUM : S_RESP;
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state = S_SQSUM;
            end
            S_SQSUM: begin
                o_cmd.sqsum = 1'b1;
                n_state = S_RESP;
            end
            S_SWEEP: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SWEEP_TAIL;
                end
            end
            S_SWEEP_TAIL: begin
                // last entry read is judged this cycle
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/plm_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module plm_dpath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  plm_pkg::t_plm_cmd            i_cmd,
    output plm_pkg::t_plm_sts            o_sts,
    input  wire [plm_pkg::TAG_W-1:0]     i_tag,
    input  wire [plm_pkg::NOW_W-1:0]     i_now,
    input  wire                          i_cfg_wr_en,
    input  wire [plm_pkg::NOW_W-1:0]     i_cfg_wr_data,
    input  wire                          i_m_tready,
    output logic                         o_m_tvalid,
    output logic [plm_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                         o_m_tuser
);
    import plm_pkg::*;

    logic [ENTRY_W-1:0]   r_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0]   r_rdata;
    logic [ADDR_W-1:0]    r_scan;
    logic [ADDR_W-1:0]    r_paddr;
    logic                 r_pend;
    logic                 r_all;
    logic [NOW_W-1:0]     r_aging;
    logic [TAG_W-1:0]     r_tag;
    logic [TIME_W-1:0]    r_now;
    logic [TIME_W-1:0]    r_limit;

    logic                 r_hit;
    logic [DELAY_W-1:0]   r_delay;
    logic [REMOVED_W-1:0] r_removed;
    logic [SUM_W-1:0]     r_square;

    logic [COUNT_W-1:0]   r_samples;
    logic [SUM_W-1:0]     r_sum;
    logic [SUM_W-1:0]     r_sqsum;
    logic [DELAY_W-1:0]   r_least;
    logic [DELAY_W-1:0]   r_greatest;
    logic                 r_have;

    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic                 r_out_hit;

    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [ENTRY_W-1:0]   wdata;
    logic [ADDR_W-1:0]    raddr;
    logic [TIME_W-1:0]    stamp;
    logic                 ent_valid;
    logic                 sweep_match;
    logic [TIME_W:0]      diff;
    logic [DELAY_W-1:0]   delay_sat;
    logic [SUM_W:0]       sum_next;
    logic [SUM_W:0]       sqsum_next;

    assign stamp       = r_rdata[TIME_W-1:0];
    assign ent_valid   = r_rdata[ENTRY_W-1];
    assign sweep_match = r_pend && ent_valid && (r_all || (stamp < r_limit));
    assign raddr       = i_cmd.scan_rd ? r_scan : ADDR_W'(i_tag);

    assign o_sts.early     = (i_now < r_aging);
    assign o_sts.hit       = ent_valid;
    assign o_sts.scan_last = (r_scan == ADDR_W'(TABLE_DEPTH - 1));
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

    // table write port: init pass, ingress stamp, egress evict, sweep evict
    always_comb begin
        we    = 1'b0;
        waddr = r_scan;
        wdata = '0;
        priority if (i_cmd.init_wr) begin
            we = 1'b1;
        end else if (i_cmd.ingress_wr) begin
            we    = 1'b1;
            waddr = ADDR_W'(i_tag);
            wdata = {1'b1, i_now};
        end else if (i_cmd.evict && ent_valid) begin
            we    = 1'b1;
            waddr = ADDR_W'(r_tag);
            wdata = {1'b0, stamp};
        end else if (sweep_match) begin
            we    = 1'b1;
            waddr = r_paddr;
            wdata = {1'b0, stamp};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    // delay: zero when the stamp is ahead of now, clipped to 32 bits
    assign diff = {1'b0, r_now} - {1'b0, stamp};
    always_comb begin
        if (diff[TIME_W]) begin
            delay_sat = '0;
        end else if (diff[TIME_W-1:DELAY_W] != '0) begin
            delay_sat = '1;
        end else begin
            delay_sat = diff[DELAY_W-1:0];
        end
    end

    assign sum_next   = {1'b0, r_sum} + {{(SUM_W - DELAY_W + 1){1'b0}}, r_delay};
    assign sqsum_next = {1'b0, r_sqsum} + {1'b0, r_square};

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= '0;
            r_pend      <= 1'b0;
            r_aging     <= AGING_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_aging <= i_cfg_wr_data;
            end
            if (i_cmd.scan_clr) begin
                r_scan <= '0;
            end else if (i_cmd.scan_rd || i_cmd.init_wr) begin
                r_scan <= r_scan + 1'b1;
            end
            r_pend <= i_cmd.scan_rd;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples  <= '0;
            r_sum      <= '0;
            r_sqsum    <= '0;
            r_least    <= '0;
            r_greatest <= '0;
            r_have     <= 1'b0;
        end else if (i_cmd.stats_clr) begin
            r_samples  <= '0;
            r_sum      <= '0;
            r_sqsum    <= '0;
            r_least    <= '0;
            r_greatest <= '0;
            r_have     <= 1'b0;
        end else if (i_cmd.accum) begin
            if (r_samples != '1) begin
                r_samples <= r_samples + 1'b1;
            end
            r_sum  <= sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
            r_have <= 1'b1;
            if (!r_have || (r_delay < r_least)) begin
                r_least <= r_delay;
            end
            if (!r_have || (r_delay > r_greatest)) begin
                r_greatest <= r_delay;
            end
        end else if (i_cmd.sqsum) begin
            r_sqsum <= sqsum_next[SUM_W] ? '1 : sqsum_next[SUM_W-1:0];
        end
    end

    // per-transaction payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_tag     <= i_tag;
            r_now     <= i_now;
            r_limit   <= i_now - r_aging;
            r_all     <= i_cmd.sweep_all;
            r_hit     <= 1'b0;
            r_delay   <= '0;
            r_removed <= '0;
        end else begin
            if (i_cmd.evict) begin
                r_hit   <= ent_valid;
                r_delay <= ent_valid ? delay_sat : '0;
            end
            if (sweep_match && (r_removed != REMOVED_MAX)) begin
                r_removed <= r_removed + 1'b1;
            end
        end
        if (i_cmd.scan_rd) begin
            r_paddr <= r_scan;
        end
        if (i_cmd.accum) begin
            r_square <= r_delay * r_delay;
        end
        if (i_cmd.out_load) begin
            r_out_hit  <= r_hit;
            r_out_data <= {{(M_TDATA_W - OUT_USED_W){1'b0}}, r_greatest, r_least,
                           r_sqsum, r_sum, r_samples, r_removed, r_delay};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_hit;

endmodule

`default_nettype wire

/* rtl/core/packet_latency_monitor.sv */
// packet latency monitor
// slave stream: tuser = mode (ingress, egress, aging sweep, clear statistics,
// clear table), tdata = packet tag and current time. master stream: one
// transaction per accepted item, tuser = hit flag, tdata = delay, removed
// count and the running statistics after this item's update.
// aging_interval is written through i_cfg_wr_en / i_cfg_wr_data; the user
// must write it only while idle, which the block itself does not enforce.
// items are handled one at a time: ingress, clear statistics, unused modes
// and an early sweep go straight to the result; an egress reads the table
// and on a hit goes on through delay, square and sum of squares; an aging
// sweep or clear table reads one table entry per cycle through the single
// read port, evicts written back in the cycle after the read.
// s_axis_tready is high only while no item is in work; it rises together with
// m_axis_tvalid. a finished result waits in the output register while the
// next item is already accepted.
// after reset the block runs a clearing pass over the table valid bits
// with s_axis_tready low; statistics and aging_interval (1000000) are reset
// at once.
// a stalled receiver holds the output register; the block then finishes the
// item in work and waits before taking another.
`timescale 1ns / 1ps
`default_nettype none

module packet_latency_monitor (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    // [9:0] packet_tag, [57:10] now_time
    input  wire [plm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] mode
    input  wire [plm_pkg::MODE_W-1:0]     s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    // [31:0] delay, [42:32] removed_count, [74:43] sample_count,
    // [138:75] delay_sum, [202:139] delay_square_sum, [234:203] min_delay,
    // [266:235] max_delay
    output logic [plm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [0] hit
    output logic                          m_axis_tuser,
    input  wire                           i_cfg_wr_en,
    input  wire [plm_pkg::NOW_W-1:0]      i_cfg_wr_data
);
    import plm_pkg::*;

    t_plm_cmd         cmd;
    t_plm_sts         sts;
    logic [TAG_W-1:0] in_tag;
    logic [NOW_W-1:0] in_now;

    assign in_tag = s_axis_tdata[TAG_W-1:0];
    assign in_now = s_axis_tdata[TAG_W +: NOW_W];

    plm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_mode     (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    plm_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_tag         (in_tag),
        .i_now         (in_now),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_m_tready    (m_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .o_m_tdata     (m_axis_tdata),
        .o_m_tuser     (m_axis_tuser)
    );

endmodule

`default_nettype wire

/* rtl/core/plm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module plm_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           s_axis_tvalid,
    input wire                           s_axis_tready,
    input wire                           m_axis_tvalid,
    input wire                           m_axis_tready,
    input wire [plm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input wire                           m_axis_tuser
);
    import plm_pkg::*;

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while previous item in work");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed under stall");

    // a hit carries a sample and no removals
    a_hit_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[OFS_REMOVED +: REMOVED_W] == '0) &&
            (m_axis_tdata[OFS_COUNT +: COUNT_W] != '0))
        else $error("hit result with removals or no samples");

    // a miss reports no delay
    a_miss_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[OFS_DELAY +: DELAY_W] == '0)
        else $error("delay reported without hit");

    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[OFS_MIN +: DELAY_W] <= m_axis_tdata[OFS_MAX +: DELAY_W])
        else $error("min delay above max delay");

endmodule

bind packet_latency_monitor plm_checker u_plm_checker (.*);

`default_nettype wire

/* test/plm_latency_checker.sv */
`timescale 1ns / 1ps

module plm_latency_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    // [9:0] packet_tag, [57:10] now_time
    input  logic [plm_pkg::S_TDATA_W-1:0] i_in_data,
    // [2:0] mode
    input  logic [plm_pkg::MODE_W-1:0]    i_in_mode,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    // [31:0] delay, [42:32] removed_count, [74:43] sample_count, [138:75] delay_sum,
    // [202:139] delay_square_sum, [234:203] min_delay, [266:235] max_delay
    input  logic [plm_pkg::M_TDATA_W-1:0] i_out_data,
    // [0] hit
    input  logic                          i_out_hit,
    input  logic                          i_cfg_wr_en,
    input  logic [plm_pkg::NOW_W-1:0]     i_cfg_wr_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_hit_count
);
    import plm_pkg::*;

    typedef struct packed {
        logic                 hit;
        logic [DELAY_W-1:0]   delay;
        logic [REMOVED_W-1:0] removed;
        logic [COUNT_W-1:0]   samples;
        logic [SUM_W-1:0]     dsum;
        logic [SUM_W-1:0]     sqsum;
        logic [DELAY_W-1:0]   dmin;
        logic [DELAY_W-1:0]   dmax;
    } t_latency_report;

    // predicted block state
    logic [TIME_W-1:0]  aging_interval;
    bit                 stamp_valid [TABLE_DEPTH];
    logic [TIME_W-1:0]  stamp_time  [TABLE_DEPTH];
    logic [COUNT_W-1:0] n_samples;
    logic [SUM_W-1:0]   sum_delay;
    logic [SUM_W-1:0]   sum_square;
    logic [DELAY_W-1:0] least_delay;
    logic [DELAY_W-1:0] greatest_delay;
    bit                 have_sample;

    t_latency_report expected_reports [$];
    int fail_count;
    int hit_count;

    function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic void clear_stats();
        n_samples      = '0;
        sum_delay      = '0;
        sum_square     = '0;
        least_delay    = '0;
        greatest_delay = '0;
        have_sample    = 1'b0;
    endfunction

    // updates the table and statistics for one transaction, returns its report
    function automatic t_latency_report predict_report(input logic [MODE_W-1:0] mode,
                                                       input logic [TAG_W-1:0]  tag,
                                                       input logic [TIME_W-1:0] now);
        t_latency_report   r;
        logic [TIME_W-1:0] diff;
        logic [TIME_W-1:0] oldest_kept;
        logic [DELAY_W-1:0] d;
        int unsigned       removed;
        r       = '0;
        removed = 0;
        case (mode)
            MODE_INGRESS: begin
                stamp_time[tag]  = now;
                stamp_valid[tag] = 1'b1;
            end
            MODE_EGRESS: begin
                if (stamp_valid[tag]) begin
                    stamp_valid[tag] = 1'b0;
                    r.hit = 1'b1;
                    // a stamp in the future reads as zero delay
                    diff = (now >= stamp_time[tag]) ? now - stamp_time[tag] : '0;
                    d = (diff[TIME_W-1:DELAY_W] != '0) ? '1 : diff[DELAY_W-1:0];
                    r.delay = d;
                    if (n_samples != '1)
                        n_samples++;
                    sum_delay  = add_sat(sum_delay, SUM_W'(d));
                    sum_square = add_sat(sum_square, SUM_W'(d) * SUM_W'(d));
                    if (!have_sample) begin
                        least_delay    = d;
                        greatest_delay = d;
                        have_sample    = 1'b1;
                    end else begin
                        if (d < least_delay)
                            least_delay = d;
                        if (d > greatest_delay)
                            greatest_delay = d;
                    end
                end
            end
            MODE_SWEEP: begin
                if (now >= aging_interval) begin
                    oldest_kept = now - aging_interval;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (stamp_valid[i] && stamp_time[i] < oldest_kept) begin
                            stamp_valid[i] = 1'b0;
                            removed++;
                        end
                    end
                end
            end
            MODE_CLR_STATS: clear_stats();
            MODE_CLR_TABLE: begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (stamp_valid[i]) begin
                        stamp_valid[i] = 1'b0;
                        removed++;
                    end
                end
            end
            default: ;
        endcase
        r.removed = (removed > REMOVED_MAX) ? REMOVED_MAX : REMOVED_W'(removed);
        r.samples = n_samples;
        r.dsum    = sum_delay;
        r.sqsum   = sum_square;
        r.dmin    = have_sample ? least_delay : '0;
        r.dmax    = have_sample ? greatest_delay : '0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                               input logic [SUM_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_latency_report want;
        if (!i_rst_n) begin
            aging_interval = AGING_RESET;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                stamp_valid[i] = 1'b0;
                stamp_time[i]  = '0;
            end
            clear_stats();
            expected_reports.delete();
            fail_count = 0;
            hit_count  = 0;
        end else begin
            // the result of an older transaction goes first
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result transaction with no item waiting");
                    fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (i_out_hit)
                        hit_count++;
                    check_field("hit", SUM_W'(want.hit), SUM_W'(i_out_hit));
                    check_field("delay", SUM_W'(want.delay),
                                SUM_W'(i_out_data[OFS_DELAY +: DELAY_W]));
                    check_field("removed_count", SUM_W'(want.removed),
                                SUM_W'(i_out_data[OFS_REMOVED +: REMOVED_W]));
                    check_field("sample_count", SUM_W'(want.samples),
                                SUM_W'(i_out_data[OFS_COUNT +: COUNT_W]));
                    check_field("delay_sum", want.dsum, i_out_data[OFS_SUM +: SUM_W]);
                    check_field("delay_square_sum", want.sqsum,
                                i_out_data[OFS_SQSUM +: SUM_W]);
                    check_field("min_delay", SUM_W'(want.dmin),
                                SUM_W'(i_out_data[OFS_MIN +: DELAY_W]));
                    check_field("max_delay", SUM_W'(want.dmax),
                                SUM_W'(i_out_data[OFS_MAX +: DELAY_W]));
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = predict_report(i_in_mode, i_in_data[TAG_W-1:0],
                                      i_in_data[TAG_W +: NOW_W]);
                expected_reports.insert(expected_reports.size(), want);
            end
            if (i_cfg_wr_en)
                aging_interval = i_cfg_wr_data;
        end
        o_fail_count = fail_count;
        o_pending    = expected_reports.size();
        o_hit_count  = hit_count;
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import plm_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
    localparam int STALL_LIMIT = 8000;
    localparam int HOLD_CYCLES = 300;
    localparam int LIVE_MAX    = 64;
    localparam logic [NOW_W-1:0] TIME_MAX = '1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [MODE_W-1:0]    s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 i_cfg_wr_en;
    logic [NOW_W-1:0]     i_cfg_wr_data;

    int fail_count;
    int pending;
    int hit_count;

    bit src_idle_on;
    bit sink_idle_on;
    bit hold_request;
    int idle_cycles;
    int mode_seen [8];
    int cfg_writes;

    logic [TAG_W-1:0] tag_pool  [32];
    logic [TAG_W-1:0] live_tags [LIVE_MAX];
    int               live_count;
    logic [NOW_W-1:0] clock_now;

    packet_latency_monitor u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    plm_latency_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_mode     (s_axis_tuser),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_hit     (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_hit_count   (hit_count)
    );

    always #5 i_clk = ~i_clk;

    // result side: random back-pressure bursts and one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            i_cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [NOW_W-1:0] rand_time();
        return NOW_W'({$urandom(), $urandom()});
    endfunction

    // entered and left just after a falling edge
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [TAG_W-1:0] tag,
                             input logic [NOW_W-1:0] now);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= S_TDATA_W'({now, tag});
        do @(posedge i_clk); while (!s_axis_tready);
        mode_seen[mode]++;
        @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_aging(input logic [NOW_W-1:0] value);
        wait_all_results();
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cfg_writes++;
    endtask

    task automatic random_item();
        int               r;
        int               idx;
        logic [TAG_W-1:0] tag;
        logic [NOW_W-1:0] now;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0)
            clock_now += NOW_W'($urandom());
        else
            clock_now += NOW_W'($urandom_range(0, 60));
        now = ($urandom_range(0, 19) == 0) ? rand_time() : clock_now;
        if (r < 45 || (r < 88 && live_count == 0)) begin
            tag = ($urandom_range(0, 9) < 7) ? tag_pool[$urandom_range(0, 31)]
                                             : TAG_W'($urandom());
            send_item(MODE_INGRESS, tag, now);
            if (live_count == LIVE_MAX)
                live_tags[$urandom_range(0, LIVE_MAX - 1)] = tag;
            else
                live_tags[live_count++] = tag;
        end else if (r < 88) begin
            // egress only on tags stamped before, swap-remove from the live list
            idx = $urandom_range(0, live_count - 1);
            tag = live_tags[idx];
            live_tags[idx] = live_tags[--live_count];
            send_item(MODE_EGRESS, tag, now);
        end else if (r < 92) begin
            send_item(MODE_SWEEP, TAG_W'($urandom()), now);
        end else if (r < 95) begin
            send_item(MODE_CLR_STATS, TAG_W'($urandom()), now);
        end else if (r < 97) begin
            send_item(MODE_CLR_TABLE, TAG_W'($urandom()), now);
        end else begin
            send_item(MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)),
                      TAG_W'($urandom()), rand_time());
        end
    endtask

    initial begin
        logic [NOW_W-1:0] aging_value;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_INGRESS;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        hold_request  = 1'b0;
        idle_cycles   = 0;
        cfg_writes    = 0;
        live_count    = 0;
        for (int i = 0; i < 32; i++)
            tag_pool[i] = TAG_W'($urandom());
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, re-stamp, future stamp, saturation, early sweep
        send_item(MODE_INGRESS, 10'd0, '0);
        send_item(MODE_INGRESS, 10'd1023, TIME_MAX);
        send_item(MODE_INGRESS, 10'd0, 48'd10);
        send_item(MODE_EGRESS, 10'd0, 48'd25);
        send_item(MODE_EGRESS, 10'd0, 48'd30);
        send_item(MODE_INGRESS, 10'd2, 48'd1000);
        send_item(MODE_EGRESS, 10'd2, 48'd500);
        send_item(MODE_INGRESS, 10'd3, '0);
        send_item(MODE_EGRESS, 10'd3, TIME_MAX);
        send_item(MODE_INGRESS, 10'd4, '0);
        send_item(MODE_EGRESS, 10'd4, 48'h1_0000_0000);
        send_item(MODE_EGRESS, 10'd1023, TIME_MAX);
        for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
            send_item(MODE_W'(m), 10'd1023, TIME_MAX);
        send_item(MODE_SWEEP, 10'd0, 48'd10);
        send_item(MODE_INGRESS, 10'd10, 48'd100);
        send_item(MODE_INGRESS, 10'd11, 48'd2000000);
        send_item(MODE_INGRESS, 10'd12, 48'd3000000);
        send_item(MODE_SWEEP, 10'd0, 48'd2500000);
        send_item(MODE_CLR_STATS, 10'd0, '0);
        send_item(MODE_CLR_TABLE, 10'd0, '0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: aging_value = '0;
                1: aging_value = TIME_MAX;
                2: aging_value = NOW_W'($urandom_range(50, 5000));
                default: aging_value = rand_time();
            endcase
            write_aging(aging_value);
            clock_now = (phase == 3) ? rand_time() : NOW_W'($urandom_range(0, 100000));
            for (int k = 0; k < 100; k++) begin
                if (k % 25 == 0) begin
                    src_idle_on  = ($urandom_range(0, 2) != 0);
                    sink_idle_on = ($urandom_range(0, 2) != 0);
                end
                if (phase == 3 && k >= 40) begin
                    src_idle_on  = 1'b0;
                    sink_idle_on = 1'b0;
                end
                if (phase == 1 && k == 20)
                    hold_request = 1'b1;
                if (phase == 2 && k == 50)
                    wait_all_results();
                random_item();
            end
        end

        wait_all_results();
        repeat (TABLE_DEPTH + 16) @(posedge i_clk);
        $display("covered %0d ingress, %0d egress (%0d hits), %0d sweeps, %0d stat clears,",
                 mode_seen[MODE_INGRESS], mode_seen[MODE_EGRESS], hit_count,
                 mode_seen[MODE_SWEEP], mode_seen[MODE_CLR_STATS]);
        $display("%0d table clears, %0d spare-mode items, %0d aging interval writes",
                 mode_seen[MODE_CLR_TABLE],
                 mode_seen[5] + mode_seen[6] + mode_seen[7], cfg_writes);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
